### rtl/core/servo_position_frame_builder_defines.svh
// Assertion macros used by the checker module of the servo frame builder.
// Needs nothing else; included by bare file name.
`ifndef SERVO_POSITION_FRAME_BUILDER_DEFINES_SVH
`define SERVO_POSITION_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPFB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/spfb_pkg.sv
// Shared types and constants of the servo position frame builder.
// Used by every module of the block; depends on nothing.
package spfb_pkg;

   localparam int SPFB_QUEUE_DEPTH = 2;

   localparam int FRAME_LEN = 14;

   // frame constants
   localparam logic [7:0] HDR_BYTE    = 8'hFF;
   localparam logic [7:0] LEN_BYTE    = 8'h0A;
   localparam logic [7:0] WRITE_INSTR = 8'h03;
   localparam logic [7:0] START_ADDR  = 8'h29;
   localparam logic [7:0] PAD_BYTE    = 8'h00;
   localparam logic [15:0] POS_SIGN_OFFSET = 16'h8000;

   // byte positions within the frame
   localparam logic [3:0] BYTE_HDR0   = 4'd0;
   localparam logic [3:0] BYTE_HDR1   = 4'd1;
   localparam logic [3:0] BYTE_ID     = 4'd2;
   localparam logic [3:0] BYTE_LEN    = 4'd3;
   localparam logic [3:0] BYTE_INSTR  = 4'd4;
   localparam logic [3:0] BYTE_ADDR   = 4'd5;
   localparam logic [3:0] BYTE_ACCEL  = 4'd6;
   localparam logic [3:0] BYTE_POS_LO = 4'd7;
   localparam logic [3:0] BYTE_POS_HI = 4'd8;
   localparam logic [3:0] BYTE_PAD0   = 4'd9;
   localparam logic [3:0] BYTE_PAD1   = 4'd10;
   localparam logic [3:0] BYTE_SPD_LO = 4'd11;
   localparam logic [3:0] BYTE_SPD_HI = 4'd12;
   localparam logic [3:0] BYTE_CHK    = 4'd13;

   // register indexes
   localparam logic [1:0] CSR_ID_LOW  = 2'd0;
   localparam logic [1:0] CSR_ID_HIGH = 2'd1;
   localparam logic [1:0] CSR_POS_LOW = 2'd2;
   localparam logic [1:0] CSR_POS_HIGH = 2'd3;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_INVALID  = 1'b1;

   typedef struct packed {
      logic [7:0]         servo_id;
      logic [7:0]         accel;
      logic signed [15:0] target_position;
      logic [15:0]        move_speed;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [3:0] byte_index;
      logic       last;
      logic       status;
   } rsp_type;

   // classified command as it waits in the queue
   typedef struct packed {
      logic        ok;
      logic [7:0]  servo_id;
      logic [7:0]  accel;
      logic [15:0] pos_enc;
      logic [15:0] move_speed;
      logic [7:0]  checksum;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

### rtl/core/spfb_front.sv
// Front end: bound registers, command acceptance, range check, position
// encoding and checksum. Depends on spfb_pkg.
module spfb_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  spfb_pkg::req_type       req,
   input  spfb_pkg::queue_stat_type q_stat,
   output logic                    push,
   output spfb_pkg::cmd_type       push_cmd
);
   import spfb_pkg::*;

   logic [7:0]         id_low_ff, id_low_in;
   logic [7:0]         id_high_ff, id_high_in;
   logic signed [15:0] pos_low_ff, pos_low_in;
   logic signed [15:0] pos_high_ff, pos_high_in;
   logic               id_ok, pos_ok;
   logic [15:0]        pos_enc;
   logic [7:0]         sum;

   always_comb begin
      id_low_in   = id_low_ff;
      id_high_in  = id_high_ff;
      pos_low_in  = pos_low_ff;
      pos_high_in = pos_high_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ID_LOW:   id_low_in   = csr_wr_data[7:0];
            CSR_ID_HIGH:  id_high_in  = csr_wr_data[7:0];
            CSR_POS_LOW:  pos_low_in  = csr_wr_data;
            CSR_POS_HIGH: pos_high_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_low_ff   <= 8'd0;
         id_high_ff  <= 8'd254;
         pos_low_ff  <= 16'sh8000;
         pos_high_ff <= 16'sh7FFF;
      end else begin
         id_low_ff   <= id_low_in;
         id_high_ff  <= id_high_in;
         pos_low_ff  <= pos_low_in;
         pos_high_ff <= pos_high_in;
      end
   end

   assign id_ok  = (req.servo_id > id_low_ff) && (req.servo_id < id_high_ff);
   assign pos_ok = (req.target_position > pos_low_ff) &&
                   (req.target_position < pos_high_ff);

   // negative goal: sign-magnitude style, offset by half range
   assign pos_enc = req.target_position[15] ?
                    POS_SIGN_OFFSET - $unsigned(req.target_position) :
                    $unsigned(req.target_position);

   // bytes 2..12; the two pad bytes add nothing
   assign sum = req.servo_id + LEN_BYTE + WRITE_INSTR + START_ADDR + req.accel +
                pos_enc[7:0] + pos_enc[15:8] +
                req.move_speed[7:0] + req.move_speed[15:8];

   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_cmd.ok         = id_ok && pos_ok;
      push_cmd.servo_id   = req.servo_id;
      push_cmd.accel      = req.accel;
      push_cmd.pos_enc    = pos_enc;
      push_cmd.move_speed = req.move_speed;
      push_cmd.checksum   = ~sum;
   end

endmodule

### rtl/core/spfb_queue.sv
// Short command queue between front and back ends, built from registers.
// Depends on spfb_pkg.
module spfb_queue #(
   parameter int DEPTH = spfb_pkg::SPFB_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  spfb_pkg::cmd_type        push_cmd,
   input  logic                     pop,
   output spfb_pkg::cmd_type        head_cmd,
   output spfb_pkg::queue_stat_type q_stat
);
   import spfb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_FULL);
   assign q_stat.empty = (count_ff == '0);

endmodule

### rtl/core/spfb_back.sv
// Back end: byte sequencer that walks the head command through the frame
// and drives the result output register. Depends on spfb_pkg.
module spfb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  spfb_pkg::cmd_type        head_cmd,
   input  spfb_pkg::queue_stat_type q_stat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output spfb_pkg::rsp_type        rsp
);
   import spfb_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       have_cmd;
   logic [7:0] frame_byte;

   assign load     = !rsp_valid_ff || rsp_ready;
   assign have_cmd = !q_stat.empty;

   always_comb begin
      case (idx_ff)
         BYTE_HDR0, BYTE_HDR1:  frame_byte = HDR_BYTE;
         BYTE_ID:               frame_byte = head_cmd.servo_id;
         BYTE_LEN:              frame_byte = LEN_BYTE;
         BYTE_INSTR:            frame_byte = WRITE_INSTR;
         BYTE_ADDR:             frame_byte = START_ADDR;
         BYTE_ACCEL:            frame_byte = head_cmd.accel;
         BYTE_POS_LO:           frame_byte = head_cmd.pos_enc[7:0];
         BYTE_POS_HI:           frame_byte = head_cmd.pos_enc[15:8];
         BYTE_PAD0, BYTE_PAD1:  frame_byte = PAD_BYTE;
         BYTE_SPD_LO:           frame_byte = head_cmd.move_speed[7:0];
         BYTE_SPD_HI:           frame_byte = head_cmd.move_speed[15:8];
         BYTE_CHK:              frame_byte = head_cmd.checksum;
         default:               frame_byte = PAD_BYTE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = have_cmd;
         if (have_cmd) begin
            if (!head_cmd.ok) begin
               rsp_in.frame_byte = PAD_BYTE;
               rsp_in.byte_index = BYTE_HDR0;
               rsp_in.last       = 1'b1;
               rsp_in.status     = STATUS_INVALID;
               pop               = 1'b1;
            end else begin
               rsp_in.frame_byte = frame_byte;
               rsp_in.byte_index = idx_ff;
               rsp_in.last       = (idx_ff == BYTE_CHK);
               rsp_in.status     = STATUS_OK;
               if (idx_ff == BYTE_CHK) begin
                  pop    = 1'b1;
                  idx_in = BYTE_HDR0;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= BYTE_HDR0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### rtl/core/servo_position_frame_builder.sv
// Servo position frame builder: top level joining front end, command queue
// and byte sequencer. Depends on spfb_pkg, spfb_front, spfb_queue, spfb_back.
//
// Each accepted command is range checked against the four bound registers
// (ID and position, both exclusive) and then turned into the 14-byte
// position-write frame FF FF id 0A 03 29 accel posL posH 00 00 spdL spdH chk,
// delivered one byte per result word with its index, a last flag on the
// checksum byte and status 0. A command that fails either check yields one
// word instead: byte 0, index 0, last 1, status 1. A good command occupies
// the byte sequencer for all 14 frame bytes, a rejected one for its single
// word; the sequencer emits one word per cycle while rsp_ready holds high
// and the queue holds a command, so the output rate is one word a clock. The
// front end takes a command in the cycle it arrives whenever the queue has a
// free slot. The command being sent stays at the queue head until its last
// word is loaded, so up to QUEUE_DEPTH - 1 commands wait behind it and
// req_ready drops only when the queue is full. On an idle block an accepted
// command goes to a queue slot register, then to the result output register.
// Write the bound registers only while the block is idle.
module servo_position_frame_builder #(
   parameter int QUEUE_DEPTH = spfb_pkg::SPFB_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  spfb_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spfb_pkg::rsp_type rsp
);
   import spfb_pkg::*;

   logic           push;
   logic           pop;
   cmd_type        push_cmd;
   cmd_type        head_cmd;
   queue_stat_type q_stat;

   // classify and encode, push into the queue
   spfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .q_stat      (q_stat),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // hold classified commands until the sequencer is free
   spfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   // walk the head command byte by byte, drop it after its last word
   spfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

### rtl/core/spfb_checker.sv
// Port-level checks of the servo position frame builder, bound to its top.
// Depends on spfb_pkg and servo_position_frame_builder_defines.svh.
`include "servo_position_frame_builder_defines.svh"

module spfb_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input spfb_pkg::rsp_type rsp
);
   import spfb_pkg::*;

   // a stalled word holds
   `SPFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp word changed while stalled")

   // a reject word carries nothing else
   `SPFB_ASSERT_NOW(a_reject_shape, clock, reset, rsp_valid && rsp.status, rsp.last && (rsp.frame_byte == PAD_BYTE) && (rsp.byte_index == BYTE_HDR0), "bad reject word")

   // a good frame ends on the checksum byte and only there
   `SPFB_ASSERT_NOW(a_last_index, clock, reset, rsp_valid && !rsp.status, rsp.last == (rsp.byte_index == BYTE_CHK), "last flag off the checksum byte")

   // a frame runs without gaps once started
   `SPFB_ASSERT_NEXT(a_no_gap, clock, reset, rsp_valid && rsp_ready && !rsp.last, rsp_valid && (rsp.byte_index == $past(rsp.byte_index) + 4'd1), "gap or skip inside a frame")

endmodule

bind servo_position_frame_builder spfb_checker u_spfb_checker (.*);
